[design/button_click_double_long_detector_assert.svh]
// Assertion macros for the button click, double click and long press detector.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BUTTON_CLICK_DOUBLE_LONG_DETECTOR_ASSERT_SVH
`define BUTTON_CLICK_DOUBLE_LONG_DETECTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCDL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcdl assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BCDL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcdl assertion failed");

`endif

[design/bcdl_pkg.sv]
// Shared types and constants for the button click, double click and long press detector.
// Has no dependencies; the top level imports it.
package bcdl_pkg;

  localparam int unsigned CNT_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_PRESS_TICKS   = 2'd0,
    CFG_DOUBLE_CLICK_TICKS = 2'd1
  } cfg_index_t;

  localparam logic [CNT_W-1:0] LONG_PRESS_TICKS_RST   = 8'd40;
  localparam logic [CNT_W-1:0] DOUBLE_CLICK_TICKS_RST = 8'd20;

endpackage

[design/button_click_double_long_detector.sv]
// Button click, double click and long press detector, one event per tick.
// The result word for an accepted tick enters the output register in the cycle after.
// Throughput: one tick word per clock unless stalled; state update is one logic pass.
// Reset (synchronous, active low): press machine idle, counters zero, no click
// pending, thresholds back to 40 and 20 ticks, output register empty.
`include "button_click_double_long_detector_assert.svh"

module button_click_double_long_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_pressed,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_event_code,
  input  logic                              cfg_we,
  input  logic [bcdl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcdl_pkg::CNT_W-1:0]        cfg_wdata
);
  import bcdl_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HELD     = 2'd2,
    PH_WAITREL  = 2'd3
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   hold_count_r, hold_count_nxt;
  logic               click_pending_r, click_pending_nxt;
  logic [CNT_W-1:0]   window_count_r, window_count_nxt;
  logic [CNT_W-1:0]   long_ticks_r, window_ticks_r;
  logic               out_valid_r;
  event_t             out_event_r, res_nxt;
  event_t             press_ev;
  logic [CNT_W-1:0]   hold_inc, window_inc;
  logic               in_fire;

  assign in_ready       = !out_valid_r || out_ready;
  assign in_fire        = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_event_code = out_event_r;

  assign hold_inc   = hold_count_r + 1'b1;
  assign window_inc = window_count_r + 1'b1;

  always_comb begin
    phase_nxt         = phase_r;
    hold_count_nxt    = hold_count_r;
    click_pending_nxt = click_pending_r;
    window_count_nxt  = window_count_r;
    press_ev          = EV_NONE;
    res_nxt           = EV_NONE;

    // Press machine: debounce over two ticks, then click on release or long press.
    case (phase_r)
      PH_IDLE: begin
        if (in_pressed) phase_nxt = PH_DEBOUNCE;
      end
      PH_DEBOUNCE: begin
        if (in_pressed) begin
          hold_count_nxt = '0;
          phase_nxt      = PH_HELD;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_HELD: begin
        if (!in_pressed) begin
          press_ev  = EV_CLICK;
          phase_nxt = PH_IDLE;
        end else begin
          hold_count_nxt = hold_inc;
          if (hold_inc >= long_ticks_r) begin
            press_ev  = EV_LONG;
            phase_nxt = PH_WAITREL;
          end
        end
      end
      PH_WAITREL: begin
        if (!in_pressed) phase_nxt = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase

    // Window machine: a pending click either pairs up or is given when the window ends.
    // A long press seen while a click is pending is dropped.
    if (!click_pending_r) begin
      if (press_ev == EV_CLICK) begin
        window_count_nxt  = '0;
        click_pending_nxt = 1'b1;
      end else begin
        res_nxt = press_ev;
      end
    end else begin
      if (press_ev == EV_CLICK) begin
        res_nxt           = EV_DOUBLE;
        click_pending_nxt = 1'b0;
      end else begin
        window_count_nxt = window_inc;
        if (window_inc >= window_ticks_r) begin
          res_nxt           = EV_CLICK;
          click_pending_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      hold_count_r    <= '0;
      click_pending_r <= 1'b0;
      window_count_r  <= '0;
      long_ticks_r    <= LONG_PRESS_TICKS_RST;
      window_ticks_r  <= DOUBLE_CLICK_TICKS_RST;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LONG_PRESS_TICKS:   long_ticks_r   <= cfg_wdata;
          CFG_DOUBLE_CLICK_TICKS: window_ticks_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire) begin
        phase_r         <= phase_nxt;
        hold_count_r    <= hold_count_nxt;
        click_pending_r <= click_pending_nxt;
        window_count_r  <= window_count_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_fire) out_event_r <= res_nxt;
  end

  // A double click always consumes the pending click.
  `BCDL_ASSERT_NEXT(a_double_clears_pending, in_fire && res_nxt == EV_DOUBLE, !click_pending_r)
  // Release after a debounced hold either pairs with a pending click or starts a window.
  `BCDL_ASSERT_NEXT(a_release_click, in_fire && phase_r == PH_HELD && !in_pressed,
                    out_event_r == EV_DOUBLE || click_pending_r)
  // A long press waiting in the output register leaves the press machine awaiting release.
  `BCDL_ASSERT_SAME(a_long_waits_release, out_valid_r && out_event_r == EV_LONG,
                    phase_r == PH_WAITREL)

endmodule
